>>> src/tag_cell_framer_checksum_top_defines.svh
// Assertion macros for the tag cell framer top level.
`ifndef TAG_CELL_FRAMER_CHECKSUM_TOP_DEFINES_SVH
`define TAG_CELL_FRAMER_CHECKSUM_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property outside reset.
`define TCFC_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property at every edge, reset included.
`define TCFC_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCFC_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define TCFC_ASSERT(lbl, clk, prop, msg)
`endif

`endif

>>> src/tcfc_pkg.sv
// Types and constants shared by the tag cell framer modules.
`default_nettype none
package tcfc_pkg;

  localparam int BYTE_BITS = 8;
  localparam int INDEX_W   = 8;

  // cell kind the sequencer emits next
  typedef enum logic [1:0] {
    PH_MARKER,
    PH_DATA,
    PH_CHECK
  } tcfc_phase_t;

  // one queued payload byte with its classification
  typedef struct packed {
    logic [BYTE_BITS-1:0] data;
    logic                 sot;   // first byte of a tag
  } tcfc_item_t;

endpackage
`default_nettype wire

>>> src/tcfc_front.sv
// Front end: accepts payload bytes, marks start-of-tag bytes, queues them.
`default_nettype none
module tcfc_front import tcfc_pkg::*; #(
  parameter int EDGE       = 8,
  parameter int CHECK_BITS = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [BYTE_BITS-1:0] in_payload_byte,
  output logic                      q_valid,
  output tcfc_item_t                q_item,
  input  wire logic                 q_pop
);

  localparam int QUAD_CELLS = (EDGE * EDGE) / 4;
  localparam int DATA_CELLS = 4 * (QUAD_CELLS - CHECK_BITS - 1);
  localparam int DC_W       = $clog2(DATA_CELLS + BYTE_BITS);

  logic [DC_W-1:0] dcnt_r, dcnt_nxt;
  tcfc_item_t      mem_r [2];
  logic            wr_r, rd_r;
  logic [1:0]      fill_r, fill_nxt;
  logic            push;
  tcfc_item_t      item;

  assign in_ready = (fill_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill_r != 2'd0);
  assign q_item   = mem_r[rd_r];

  // Count data cells consumed in the current tag; a byte that reaches the
  // end of the tag's data closes it and the next byte opens a new tag.
  always_comb begin
    item.data = in_payload_byte;
    item.sot  = (dcnt_r == '0);
    if (dcnt_r + DC_W'(BYTE_BITS) >= DC_W'(DATA_CELLS)) begin
      dcnt_nxt = '0;
    end else begin
      dcnt_nxt = dcnt_r + DC_W'(BYTE_BITS);
    end
    fill_nxt = fill_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
      wr_r   <= 1'b0;
      rd_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (push) begin
        dcnt_r <= dcnt_nxt;
        wr_r   <= ~wr_r;
      end
      if (q_pop) begin
        rd_r <= ~rd_r;
      end
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= item;
    end
  end

endmodule
`default_nettype wire

>>> src/tcfc_back.sv
// Back end: cell sequencer emitting marker, data and checksum cells.
`default_nettype none
module tcfc_back import tcfc_pkg::*; #(
  parameter int EDGE       = 8,
  parameter int CHECK_BITS = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire tcfc_item_t         q_item,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_cell_value,
  output logic [INDEX_W-1:0]      out_cell_index,
  output logic                    out_tag_done,
  output logic                    out_last
);

  localparam int QUAD_CELLS = (EDGE * EDGE) / 4;
  localparam int TAG_CELLS  = 4 * QUAD_CELLS;
  localparam int DATA_END   = QUAD_CELLS - CHECK_BITS;
  localparam int POS_W      = $clog2(TAG_CELLS);
  localparam int QOFF_W     = $clog2(QUAD_CELLS);
  localparam int CK_W       = (CHECK_BITS > 1) ? $clog2(CHECK_BITS) : 1;
  localparam int BL_W       = $clog2(BYTE_BITS + 1);

  tcfc_phase_t           phase_r, phase_nxt;
  logic                  cur_valid_r, cur_valid_nxt;
  logic [BYTE_BITS-1:0]  data_r, data_nxt;
  logic [BL_W-1:0]       bits_r, bits_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [QOFF_W-1:0]     qoff_r, qoff_nxt;
  logic [CHECK_BITS-1:0] cnt_r, cnt_nxt;
  logic [CK_W-1:0]       ck_r, ck_nxt;

  logic                  out_valid_r;
  logic                  out_value_r, out_done_r, out_last_r;
  logic [INDEX_W-1:0]    out_index_r;

  logic advance, emit, byte_end, load;
  logic cell_v, cell_done;

  assign advance = !out_valid_r || out_ready;
  assign emit    = cur_valid_r && advance;

  always_comb begin
    phase_nxt     = phase_r;
    cur_valid_nxt = cur_valid_r;
    data_nxt      = data_r;
    bits_nxt      = bits_r;
    pos_nxt       = pos_r;
    qoff_nxt      = qoff_r;
    cnt_nxt       = cnt_r;
    ck_nxt        = ck_r;
    cell_v        = 1'b0;
    cell_done     = 1'b0;
    byte_end      = 1'b0;

    if (emit) begin
      pos_nxt  = pos_r + 1'b1;
      qoff_nxt = qoff_r + 1'b1;
      unique case (phase_r)
        PH_MARKER: begin
          cell_v  = (pos_r == '0);
          cnt_nxt = CHECK_BITS'(cell_v);
          if (bits_r == '0) begin
            byte_end = 1'b1;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          cell_v   = data_r[BYTE_BITS-1];
          data_nxt = data_r << 1;
          bits_nxt = bits_r - 1'b1;
          cnt_nxt  = cnt_r + CHECK_BITS'(cell_v);
          if (qoff_r == QOFF_W'(DATA_END - 1)) begin
            phase_nxt = PH_CHECK;
            ck_nxt    = CK_W'(CHECK_BITS - 1);
          end else if (bits_r == BL_W'(1)) begin
            byte_end = 1'b1;
          end
        end
        PH_CHECK: begin
          cell_v = cnt_r[ck_r];
          ck_nxt = ck_r - 1'b1;
          if (ck_r == '0) begin
            qoff_nxt = '0;
            if (pos_r == POS_W'(TAG_CELLS - 1)) begin
              // tag complete: drop the byte's remaining bits
              cell_done = 1'b1;
              byte_end  = 1'b1;
              pos_nxt   = '0;
              cnt_nxt   = '0;
            end else begin
              phase_nxt = PH_MARKER;
            end
          end
        end
        default: begin
          phase_nxt = PH_MARKER;
        end
      endcase
    end

    load = q_valid && (!cur_valid_r || (emit && byte_end));
    if (load) begin
      cur_valid_nxt = 1'b1;
      data_nxt      = q_item.data;
      bits_nxt      = BL_W'(BYTE_BITS);
      phase_nxt     = q_item.sot ? PH_MARKER : PH_DATA;
    end else if (emit && byte_end) begin
      cur_valid_nxt = 1'b0;
    end
  end

  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_MARKER;
      cur_valid_r <= 1'b0;
      pos_r       <= '0;
      qoff_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cur_valid_r <= cur_valid_nxt;
      pos_r       <= pos_nxt;
      qoff_r      <= qoff_nxt;
      cnt_r       <= cnt_nxt;
      if (advance) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    bits_r <= bits_nxt;
    ck_r   <= ck_nxt;
    if (emit) begin
      out_value_r <= cell_v;
      out_index_r <= INDEX_W'(pos_r);
      out_done_r  <= cell_done;
      out_last_r  <= byte_end;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_value = out_value_r;
  assign out_cell_index = out_index_r;
  assign out_tag_done   = out_done_r;
  assign out_last       = out_last_r;

endmodule
`default_nettype wire

>>> src/tag_cell_framer_checksum_top.sv
// Top level of the tag cell framer: byte queue front end and cell sequencer.
//
// Input channel in_valid/in_ready carries one payload byte per transaction.
// Output channel out_valid/out_ready carries one tag cell per transaction:
// its value, its index in quadrant-major order, a tag-done flag on the final
// checksum cell of the tag and a last flag on the final cell of each byte.
// Each quadrant holds a marker cell (1 in quadrant 0), data cells taken
// MSB first, and CHECK_BITS checksum cells (popcount, MSB first).
// Throughput: one cell per cycle while bytes are queued and out_ready is high; a byte
// yields 8 to 13 cells for the default size, about 11 on average. The single
// cell-per-cycle output register sets this rate.
// Path: an accepted byte is registered in a queue entry, then in the sequencer's
// byte register, and its first cell is then registered in the output register.
// A two-entry queue takes bytes while the sequencer works and while a cell
// waits on out_ready; a stalled receiver holds the cell and backs up the
// queue, then in_ready falls.
// Reset starts a fresh tag at cell 0 and empties the queue.
`default_nettype none
`include "tag_cell_framer_checksum_top_defines.svh"
module tag_cell_framer_checksum_top import tcfc_pkg::*; #(
  parameter int EDGE       = 8,
  parameter int CHECK_BITS = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [BYTE_BITS-1:0] in_payload_byte,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_cell_value,
  output logic [INDEX_W-1:0]        out_cell_index,
  output logic                      out_tag_done,
  output logic                      out_last
);

  localparam int QUAD_CELLS = (EDGE * EDGE) / 4;
  localparam int TAG_CELLS  = 4 * QUAD_CELLS;

  logic       q_valid;
  logic       q_pop;
  tcfc_item_t q_item;

  tcfc_front #(
    .EDGE       (EDGE),
    .CHECK_BITS (CHECK_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_payload_byte (in_payload_byte),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  tcfc_back #(
    .EDGE       (EDGE),
    .CHECK_BITS (CHECK_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_value (out_cell_value),
    .out_cell_index (out_cell_index),
    .out_tag_done   (out_tag_done),
    .out_last       (out_last)
  );

  `TCFC_ASSERT(a_reset_idle, clk, !rst_n |=> !out_valid, "output valid after reset")
  `TCFC_ASSERT_RST(a_done_last, clk, rst_n, out_valid && out_tag_done |-> out_last, "tag end without last")
  `TCFC_ASSERT_RST(a_done_index, clk, rst_n, out_valid && out_tag_done |-> out_cell_index == INDEX_W'(TAG_CELLS - 1), "tag end at wrong index")
  `TCFC_ASSERT_RST(a_restart, clk, rst_n, out_valid && out_ready && out_tag_done |=> !out_valid || out_cell_index == '0, "new tag not at cell 0")
  `TCFC_ASSERT_RST(a_first_marker, clk, rst_n, out_valid && out_cell_index == '0 |-> out_cell_value, "quadrant 0 marker not set")

endmodule
`default_nettype wire

>>> test/tag_cell_framer_checksum_checker.sv
// Checker for the tag cell framer: predicts each byte's cells and compares the cell stream.
`default_nettype none
module tag_cell_framer_checksum_checker import tcfc_pkg::*; #(
  parameter int EDGE       = 8,
  parameter int CHECK_BITS = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_ready,
  input  wire logic [BYTE_BITS-1:0] in_payload_byte,
  input  wire logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire logic                 out_cell_value,
  input  wire logic [INDEX_W-1:0]   out_cell_index,
  input  wire logic                 out_tag_done,
  input  wire logic                 out_last,
  output int                        fail_count,
  output int                        cells_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUAD_CELLS = (EDGE * EDGE) / 4;
  localparam int TAG_CELLS  = 4 * QUAD_CELLS;
  localparam int DATA_END   = QUAD_CELLS - CHECK_BITS;

  typedef struct {
    logic               value;
    logic [INDEX_W-1:0] index;
    logic               done;
    logic               last;
  } tag_cell_t;

  tag_cell_t             cell_q[$];
  int unsigned           cell_pos;
  logic [CHECK_BITS-1:0] ones;
  int                    errs;
  int                    seen;

  function automatic void push_cell(input logic value, input logic done);
    cell_q.push_back('{value, INDEX_W'(cell_pos), done, 1'b0});
    cell_pos++;
  endfunction

  // Orientation cell restarts the quadrant's one count.
  function automatic void put_marker();
    logic v;
    v    = (cell_pos == 0);
    ones = CHECK_BITS'(v);
    push_cell(v, 1'b0);
  endfunction

  function automatic void frame_byte(input logic [BYTE_BITS-1:0] b);
    logic [CHECK_BITS-1:0] sum;
    if (cell_pos >= TAG_CELLS) cell_pos = 0;
    if (cell_pos == 0) put_marker();
    for (int i = BYTE_BITS - 1; i >= 0; i--) begin
      push_cell(b[i], 1'b0);
      ones = ones + CHECK_BITS'(b[i]);
      if ((cell_pos % QUAD_CELLS) == DATA_END) begin
        sum = ones;
        for (int k = CHECK_BITS - 1; k >= 0; k--)
          push_cell(sum[k], (k == 0) && (cell_pos + 1 == TAG_CELLS));
        // Drop the rest of the byte at the end of the tag.
        if (cell_pos >= TAG_CELLS) begin
          cell_pos = 0;
          ones     = '0;
          break;
        end
        put_marker();
      end
    end
    cell_q[cell_q.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    tag_cell_t want;
    if (!rst_n) begin
      cell_q.delete();
      cell_pos = 0;
      ones     = '0;
    end else begin
      if (in_valid && in_ready) frame_byte(in_payload_byte);
      if (out_valid && out_ready) begin
        if (cell_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("cell %0d: unexpected, got value %0b index %0d done %0b last %0b",
                     seen, out_cell_value, out_cell_index, out_tag_done, out_last);
        end else begin
          want = cell_q.pop_front();
          if (out_cell_value !== want.value || out_cell_index !== want.index ||
              out_tag_done !== want.done || out_last !== want.last) begin
            errs++;
            if (errs <= 10)
              $display({"cell %0d: expected value %0b index %0d done %0b last %0b,",
                        " got value %0b index %0d done %0b last %0b"},
                       seen, want.value, want.index, want.done, want.last,
                       out_cell_value, out_cell_index, out_tag_done, out_last);
          end
        end
        seen++;
      end
    end
    fail_count    <= errs;
    cells_pending <= cell_q.size();
  end

endmodule
`default_nettype wire

>>> test/testbench.sv
// Top of the tag cell framer testbench: clock, reset, byte stimulus, receiver stalls, verdict.
`default_nettype none
module testbench import tcfc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EDGE       = 8;
  localparam int CHECK_BITS = 4;
  localparam int IDLE_LIMIT = 1000;
  localparam int RAND_BYTES = 400;
  localparam int CALM_BYTES = 60;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [BYTE_BITS-1:0] in_payload_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_cell_value;
  logic [INDEX_W-1:0]   out_cell_index;
  logic                 out_tag_done;
  logic                 out_last;
  int                   fail_count;
  int                   cells_pending;
  bit                   calm;

  tag_cell_framer_checksum_top #(.EDGE(EDGE), .CHECK_BITS(CHECK_BITS)) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_payload_byte (in_payload_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cell_value  (out_cell_value),
    .out_cell_index  (out_cell_index),
    .out_tag_done    (out_tag_done),
    .out_last        (out_last)
  );

  tag_cell_framer_checksum_checker #(.EDGE(EDGE), .CHECK_BITS(CHECK_BITS)) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_payload_byte (in_payload_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cell_value  (out_cell_value),
    .out_cell_index  (out_cell_index),
    .out_tag_done    (out_tag_done),
    .out_last        (out_last),
    .fail_count      (fail_count),
    .cells_pending   (cells_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hold valid high across back-to-back transactions; lower it only for a gap.
  task automatic send_byte(input logic [BYTE_BITS-1:0] b, input bit gaps);
    int gap;
    in_valid        <= 1'b1;
    in_payload_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid        <= 1'b0;
      in_payload_byte <= BYTE_BITS'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_cells();
    in_valid <= 1'b0;
    @(posedge clk);
    while (cells_pending != 0) @(posedge clk);
  endtask

  function automatic logic [BYTE_BITS-1:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return BYTE_BITS'($urandom_range(0, 255));
    endcase
  endfunction

  // Receiver: random stall bursts, none in the calm tail.
  initial begin
    int hold;
    hold = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (calm) begin
        out_ready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        hold = $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long.
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("tag_cell_framer_checksum_top: mismatch");
    $finish;
  end

  initial begin
    logic [BYTE_BITS-1:0] directed[$];
    bit quiet_phase;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_payload_byte <= '0;
    calm            <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // All-ones tag, all-zeros tag, then mixed bit patterns; each tag ends mid-byte.
    directed = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                 8'h80, 8'h01, 8'hAA, 8'h55, 8'h7F, 8'hFE,
                 8'h0F, 8'hF0, 8'hC3};
    foreach (directed[i]) send_byte(directed[i], 1'b1);
    drain_cells();

    quiet_phase = 1'b0;
    for (int n = 0; n < RAND_BYTES; n++) begin
      if (n == RAND_BYTES / 2) drain_cells();
      if (n == RAND_BYTES - CALM_BYTES) begin
        quiet_phase = 1'b1;
        calm <= 1'b1;
      end
      send_byte(pick_byte(), !quiet_phase && (n % 100) < 70);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (cells_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && cells_pending == 0) begin
      $display("tag_cell_framer_checksum_top: match");
    end else begin
      $display("tag_cell_framer_checksum_top: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
+incdir+src
src/tcfc_pkg.sv
src/tcfc_front.sv
src/tcfc_back.sv
src/tag_cell_framer_checksum_top.sv
test/tag_cell_framer_checksum_checker.sv
test/testbench.sv
